@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the keyboard fifo block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every rising edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen on a rising edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ hw/rtl/kbdfifo_pkg.sv @@
package kbdfifo_pkg;

  // default character queue depth, holds one less than this
  localparam int QUEUE_DEPTH_DEF = 128;

  // request actions
  localparam logic [1:0] ACT_SCAN = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_EOF  = 2'd2;

  // scan code set 1 values
  localparam logic [7:0] REL_BIT   = 8'h80;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_LCTRL  = 7'h1D;
  localparam logic [6:0] SC_KEY_C  = 7'h2E;
  localparam logic [6:0] SC_KEY_D  = 7'h20;

  localparam logic [6:0] ASCII_LOW_A = 7'h61;
  localparam logic [6:0] ASCII_LOW_Z = 7'h7A;

  // unshifted us layout, codes 0x00 to 0x3f
  function automatic logic [6:0] rom_plain(input logic [5:0] code);
    logic [6:0] ch;
    case (code)
      6'h02: ch = 7'h31;  6'h03: ch = 7'h32;  6'h04: ch = 7'h33;  6'h05: ch = 7'h34;
      6'h06: ch = 7'h35;  6'h07: ch = 7'h36;  6'h08: ch = 7'h37;  6'h09: ch = 7'h38;
      6'h0A: ch = 7'h39;  6'h0B: ch = 7'h30;  6'h0C: ch = 7'h2D;  6'h0D: ch = 7'h3D;
      6'h0E: ch = 7'h08;  6'h0F: ch = 7'h09;  6'h10: ch = 7'h71;  6'h11: ch = 7'h77;
      6'h12: ch = 7'h65;  6'h13: ch = 7'h72;  6'h14: ch = 7'h74;  6'h15: ch = 7'h79;
      6'h16: ch = 7'h75;  6'h17: ch = 7'h69;  6'h18: ch = 7'h6F;  6'h19: ch = 7'h70;
      6'h1A: ch = 7'h5B;  6'h1B: ch = 7'h5D;  6'h1C: ch = 7'h0A;  6'h1E: ch = 7'h61;
      6'h1F: ch = 7'h73;  6'h20: ch = 7'h64;  6'h21: ch = 7'h66;  6'h22: ch = 7'h67;
      6'h23: ch = 7'h68;  6'h24: ch = 7'h6A;  6'h25: ch = 7'h6B;  6'h26: ch = 7'h6C;
      6'h27: ch = 7'h3B;  6'h28: ch = 7'h27;  6'h29: ch = 7'h60;  6'h2B: ch = 7'h5C;
      6'h2C: ch = 7'h7A;  6'h2D: ch = 7'h78;  6'h2E: ch = 7'h63;  6'h2F: ch = 7'h76;
      6'h30: ch = 7'h62;  6'h31: ch = 7'h6E;  6'h32: ch = 7'h6D;  6'h33: ch = 7'h2C;
      6'h34: ch = 7'h2E;  6'h35: ch = 7'h2F;  6'h37: ch = 7'h2A;  6'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // shifted us layout, codes 0x00 to 0x3f
  function automatic logic [6:0] rom_shift(input logic [5:0] code);
    logic [6:0] ch;
    case (code)
      6'h02: ch = 7'h21;  6'h03: ch = 7'h40;  6'h04: ch = 7'h23;  6'h05: ch = 7'h24;
      6'h06: ch = 7'h25;  6'h07: ch = 7'h5E;  6'h08: ch = 7'h26;  6'h09: ch = 7'h2A;
      6'h0A: ch = 7'h28;  6'h0B: ch = 7'h29;  6'h0C: ch = 7'h5F;  6'h0D: ch = 7'h2B;
      6'h0E: ch = 7'h08;  6'h0F: ch = 7'h09;  6'h10: ch = 7'h51;  6'h11: ch = 7'h57;
      6'h12: ch = 7'h45;  6'h13: ch = 7'h52;  6'h14: ch = 7'h54;  6'h15: ch = 7'h59;
      6'h16: ch = 7'h55;  6'h17: ch = 7'h49;  6'h18: ch = 7'h4F;  6'h19: ch = 7'h50;
      6'h1A: ch = 7'h7B;  6'h1B: ch = 7'h7D;  6'h1C: ch = 7'h0A;  6'h1E: ch = 7'h41;
      6'h1F: ch = 7'h53;  6'h20: ch = 7'h44;  6'h21: ch = 7'h46;  6'h22: ch = 7'h47;
      6'h23: ch = 7'h48;  6'h24: ch = 7'h4A;  6'h25: ch = 7'h4B;  6'h26: ch = 7'h4C;
      6'h27: ch = 7'h3A;  6'h28: ch = 7'h22;  6'h29: ch = 7'h7E;  6'h2B: ch = 7'h7C;
      6'h2C: ch = 7'h5A;  6'h2D: ch = 7'h58;  6'h2E: ch = 7'h43;  6'h2F: ch = 7'h56;
      6'h30: ch = 7'h42;  6'h31: ch = 7'h4E;  6'h32: ch = 7'h4D;  6'h33: ch = 7'h3C;
      6'h34: ch = 7'h3E;  6'h35: ch = 7'h3F;  6'h37: ch = 7'h2A;  6'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ hw/rtl/kbdfifo_req_if.sv @@
interface kbdfifo_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] scan_code;

  modport source (output valid, action, scan_code, input ready);
  modport sink (input valid, action, scan_code, output ready);
endinterface

@@ hw/rtl/kbdfifo_rsp_if.sv @@
interface kbdfifo_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] read_data;
  logic       eof_seen;
  logic       raise_interrupt;
  logic       wake_readers;
  logic       char_queued;

  modport source (
    output valid, read_data, eof_seen, raise_interrupt, wake_readers, char_queued,
    input ready
  );
  modport sink (
    input valid, read_data, eof_seen, raise_interrupt, wake_readers, char_queued,
    output ready
  );
endinterface

@@ hw/rtl/scancode_to_ascii_keyboard_fifo_unit.sv @@
// keyboard decoder with a character queue
// req channel: one request per transfer; action selects a scan code byte,
//   a character read or a test-and-clear of the end-of-input flag
// rsp channel: exactly one result per request, in request order
// scan code presses go through the us ascii tables with shift, caps lock and
//   left ctrl tracking; characters go into a ring queue of QUEUE_DEPTH slots
//   that holds QUEUE_DEPTH-1 characters and drops new ones when full
// ctrl-c gives raise_interrupt, ctrl-d sets the end-of-input flag
// a taken request passes the memory read stage and then the result register
//   before rsp.valid rises; the queue memory read is registered
// throughput: one request per cycle, sustained while rsp.ready is high; the
//   modifier flags and the queue pointers are updated in the cycle a request
//   is taken, so the next request may follow straight away
// reset clears modifiers, the flag and both pointers; queue contents are
//   not cleared, no entry is read before it is written
// a stalled rsp.ready holds the result register; one more request may be
//   taken into the memory read stage, then req.ready drops until space frees
`include "assert_macros.svh"

module scancode_to_ascii_keyboard_fifo_unit
  import kbdfifo_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic            clk,
  input logic            rst,
  kbdfifo_req_if.sink    req,
  kbdfifo_rsp_if.source  rsp
);

  localparam int AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic rd_hit;
    logic eof_seen;
    logic irq;
    logic wake;
    logic queued;
  } res_t;

  // architectural state
  logic          shift_down, shift_down_next;
  logic          caps_lock_on, caps_lock_on_next;
  logic          ctrl_down, ctrl_down_next;
  logic          eof_pending, eof_pending_next;
  logic [AW-1:0] write_slot, read_slot;
  logic [6:0]    char_queue [QUEUE_DEPTH];
  logic [6:0]    mem_q;

  // pipeline registers
  logic          s1_valid;
  res_t          s1_res;
  logic          out_valid;
  logic [6:0]    out_read_data;
  res_t          out_res;

  // request decode
  logic          in_acc;
  logic          s1_advance;
  logic [6:0]    code;
  logic [6:0]    plain_ch, shift_ch, dec_ch;
  logic          alpha_key, use_shift;
  logic [AW-1:0] write_inc, read_inc;
  logic          queue_full, queue_empty;
  logic          push_en, pop_en;
  res_t          res;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;
  assign in_acc     = req.valid && req.ready;

  // table lookup and letter case selection
  assign code      = req.scan_code[6:0];
  assign plain_ch  = req.scan_code[6] ? 7'h00 : rom_plain(req.scan_code[5:0]);
  assign shift_ch  = req.scan_code[6] ? 7'h00 : rom_shift(req.scan_code[5:0]);
  assign alpha_key = (plain_ch >= ASCII_LOW_A) && (plain_ch <= ASCII_LOW_Z);
  assign use_shift = alpha_key ? (shift_down ^ caps_lock_on) : shift_down;
  assign dec_ch    = use_shift ? shift_ch : plain_ch;

  // ring pointers
  assign write_inc   = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign read_inc    = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;
  assign queue_full  = (write_inc == read_slot);
  assign queue_empty = (write_slot == read_slot);

  // action handling
  always_comb begin
    shift_down_next   = shift_down;
    caps_lock_on_next = caps_lock_on;
    ctrl_down_next    = ctrl_down;
    eof_pending_next  = eof_pending;
    push_en           = 1'b0;
    pop_en            = 1'b0;
    res               = '0;
    case (req.action)
      ACT_SCAN: begin
        if ((req.scan_code & REL_BIT) != 8'h00) begin
          if (code == SC_LSHIFT || code == SC_RSHIFT) shift_down_next = 1'b0;
          if (code == SC_LCTRL) ctrl_down_next = 1'b0;
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
          shift_down_next = 1'b1;
        end else if (code == SC_CAPS) begin
          caps_lock_on_next = !caps_lock_on;
        end else if (code == SC_LCTRL) begin
          ctrl_down_next = 1'b1;
        end else if (ctrl_down) begin
          if (code == SC_KEY_C) begin
            res.irq = 1'b1;
          end else if (code == SC_KEY_D) begin
            eof_pending_next = 1'b1;
            res.wake         = 1'b1;
          end
        end else if (dec_ch != 7'h00) begin
          res.wake   = 1'b1;
          push_en    = !queue_full;
          res.queued = !queue_full;
        end
      end
      ACT_READ: begin
        pop_en     = !queue_empty;
        res.rd_hit = !queue_empty;
      end
      ACT_EOF: begin
        res.eof_seen     = eof_pending;
        eof_pending_next = 1'b0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // modifier, flag and pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_down   <= 1'b0;
      caps_lock_on <= 1'b0;
      ctrl_down    <= 1'b0;
      eof_pending  <= 1'b0;
      write_slot   <= '0;
      read_slot    <= '0;
    end else if (in_acc) begin
      shift_down   <= shift_down_next;
      caps_lock_on <= caps_lock_on_next;
      ctrl_down    <= ctrl_down_next;
      eof_pending  <= eof_pending_next;
      if (push_en) write_slot <= write_inc;
      if (pop_en) read_slot <= read_inc;
    end
  end

  // queue memory write port
  always_ff @(posedge clk) begin
    if (in_acc && push_en) char_queue[write_slot] <= dec_ch;
  end

  // queue memory registered read port
  always_ff @(posedge clk) begin
    if (in_acc && pop_en) mem_q <= char_queue[read_slot];
  end

  // memory read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_res <= res;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_read_data <= s1_res.rd_hit ? mem_q : 7'h00;
      out_res       <= s1_res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.read_data       = out_read_data;
  assign rsp.eof_seen        = out_res.eof_seen;
  assign rsp.raise_interrupt = out_res.irq;
  assign rsp.wake_readers    = out_res.wake;
  assign rsp.char_queued     = out_res.queued;

  // checks
  logic [3:0] excl_flags;
  assign excl_flags = {s1_res.rd_hit, s1_res.eof_seen, s1_res.irq, s1_res.wake};

  `ASSERT_CLK(a_one_kind, !s1_valid || $onehot0(excl_flags), "result mixes kinds")
  `ASSERT_CLK(a_queued_wakes, !(s1_valid && s1_res.queued) || s1_res.wake, "store without wake")
  `ASSERT_CLK(a_full_holds, (in_acc && push_en) |=> (write_slot != read_slot), "queue overrun")
  `ASSERT_NEVER(a_stall_cause, !req.ready && !(s1_valid && out_valid), "ready low with space")

endmodule

@@ tb/scancode_to_ascii_keyboard_fifo_unit_tb.sv @@
`timescale 1ns / 1ps

module scancode_to_ascii_keyboard_fifo_unit_tb
  import kbdfifo_pkg::*;
();

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 1000;
  localparam int MAX_REPORTS = 10;

  // action code that the block ignores
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [6:0] read_data;
    logic       eof_seen;
    logic       raise_interrupt;
    logic       wake_readers;
    logic       char_queued;
  } kbd_result_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE, RX_LONG_STALLS} rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  kbdfifo_req_if req_ch ();
  kbdfifo_rsp_if rsp_ch ();

  scancode_to_ascii_keyboard_fifo_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // us layout tables, codes 0x00 to 0x3f
  logic [7:0] us_plain [64] = '{
    8'h00, 8'h00, "1",   "2",   "3",   "4",   "5",   "6",
    "7",   "8",   "9",   "0",   "-",   "=",   8'h08, 8'h09,
    "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
    "o",   "p",   "[",   "]",   8'h0A, 8'h00, "a",   "s",
    "d",   "f",   "g",   "h",   "j",   "k",   "l",   ";",
    "'",   8'h60, 8'h00, "\\",  "z",   "x",   "c",   "v",
    "b",   "n",   "m",   ",",   ".",   "/",   8'h00, "*",
    8'h00, " ",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [7:0] us_shifted [64] = '{
    8'h00, 8'h00, "!",   "@",   "#",   "$",   "%",   "^",
    "&",   "*",   "(",   ")",   "_",   "+",   8'h08, 8'h09,
    "Q",   "W",   "E",   "R",   "T",   "Y",   "U",   "I",
    "O",   "P",   "{",   "}",   8'h0A, 8'h00, "A",   "S",
    "D",   "F",   "G",   "H",   "J",   "K",   "L",   ":",
    "\"",  "~",   8'h00, "|",   "Z",   "X",   "C",   "V",
    "B",   "N",   "M",   "<",   ">",   "?",   8'h00, "*",
    8'h00, " ",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // keyboard state as the block should hold it
  logic        shift_active;
  logic        caps_on;
  logic        ctrl_active;
  logic        eof_flag;
  logic [6:0]  typed_chars [$];
  kbd_result_t expected_results [$];

  int unsigned requests_sent;
  int unsigned results_checked = 0;
  int unsigned failures = 0;
  int unsigned chars_stored;
  int unsigned chars_dropped;
  int unsigned interrupts_seen;
  int unsigned eof_hits;
  int unsigned empty_reads;

  int          burst_left;
  int          sender_max_gap;
  int          idle_cycles = 0;
  int unsigned rx_cycle = 0;
  int          stall_left = 0;
  rx_mode_t    stall_mode = RX_RANDOM;

  // works out the result of one request and moves the keyboard state on
  function automatic kbd_result_t decode_request(input logic [1:0] act,
                                                 input logic [7:0] code);
    kbd_result_t r;
    logic [6:0]  key;
    logic [7:0]  ch;
    logic        letter;
    logic        shifted;
    r = '0;
    key = code[6:0];
    case (act)
      ACT_SCAN: begin
        if (code[7]) begin
          // releases only matter for the held modifiers
          if (key == SC_LSHIFT || key == SC_RSHIFT) shift_active = 1'b0;
          if (key == SC_LCTRL) ctrl_active = 1'b0;
        end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
          shift_active = 1'b1;
        end else if (key == SC_CAPS) begin
          caps_on = !caps_on;
        end else if (key == SC_LCTRL) begin
          ctrl_active = 1'b1;
        end else if (ctrl_active) begin
          if (key == SC_KEY_C) begin
            r.raise_interrupt = 1'b1;
            interrupts_seen++;
          end else if (key == SC_KEY_D) begin
            eof_flag = 1'b1;
            r.wake_readers = 1'b1;
          end
        end else if (key < 7'd64) begin
          ch = us_plain[key[5:0]];
          letter = (ch >= "a" && ch <= "z");
          shifted = letter ? (shift_active ^ caps_on) : shift_active;
          if (shifted) ch = us_shifted[key[5:0]];
          if (ch != 8'h00) begin
            r.wake_readers = 1'b1;
            if (typed_chars.size() < QUEUE_DEPTH - 1) begin
              typed_chars.push_back(ch[6:0]);
              r.char_queued = 1'b1;
              chars_stored++;
            end else begin
              chars_dropped++;
            end
          end
        end
      end
      ACT_READ: begin
        if (typed_chars.size() != 0) r.read_data = typed_chars.pop_front();
        else empty_reads++;
      end
      ACT_EOF: begin
        if (eof_flag) begin
          eof_flag = 1'b0;
          r.eof_seen = 1'b1;
          eof_hits++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  // one request, with bursts and random gaps on the sending side
  task automatic send_request(input logic [1:0] act, input logic [7:0] code);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_max_gap == 0 || $urandom_range(0, 3) == 0) ?
            0 : $urandom_range(1, sender_max_gap);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) begin
          req_ch.action    <= 2'($urandom);
          req_ch.scan_code <= 8'($urandom);
          @(posedge clk);
        end
      end
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.scan_code <= code;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_results.push_back(decode_request(act, code));
    requests_sent++;
    burst_left--;
  endtask

  task automatic tap_key(input logic [7:0] code);
    send_request(ACT_SCAN, code);
    send_request(ACT_SCAN, code | REL_BIT);
  endtask

  // a plain letter, then shift on the 1 key for a symbol
  task automatic test_letters_and_shift();
    tap_key(8'h1E);
    send_request(ACT_SCAN, {1'b0, SC_LSHIFT});
    send_request(ACT_SCAN, 8'h02);
    send_request(ACT_SCAN, {1'b1, SC_LSHIFT});
  endtask

  // caps lock flips letters only, shift undoes it
  task automatic test_caps_lock();
    send_request(ACT_SCAN, {1'b0, SC_CAPS});
    send_request(ACT_SCAN, 8'h1E);
    send_request(ACT_SCAN, 8'h02);
    send_request(ACT_SCAN, {1'b0, SC_RSHIFT});
    send_request(ACT_SCAN, 8'h1E);
    send_request(ACT_SCAN, {1'b1, SC_RSHIFT});
    send_request(ACT_SCAN, {1'b0, SC_CAPS});
  endtask

  // ctrl-c interrupt, ctrl-d end of input, other ctrl keys silent
  task automatic test_ctrl_keys();
    send_request(ACT_SCAN, {1'b0, SC_LCTRL});
    send_request(ACT_SCAN, {1'b0, SC_KEY_C});
    send_request(ACT_SCAN, {1'b0, SC_KEY_D});
    send_request(ACT_SCAN, 8'h1E);
    send_request(ACT_SCAN, {1'b1, SC_LCTRL});
    send_request(ACT_EOF, 8'hFF);
    send_request(ACT_EOF, 8'h00);
  endtask

  // unmapped codes, extension prefix, unused action, reads with junk code
  task automatic test_odd_codes();
    send_request(ACT_SCAN, 8'h3F);
    send_request(ACT_SCAN, 8'hFF);
    send_request(ACT_SCAN, 8'hE0);
    send_request(ACT_SCAN, 8'h1C);
    send_request(ACT_NONE, 8'hFF);
    send_request(ACT_READ, 8'h5A);
    send_request(ACT_READ, 8'hA5);
  endtask

  // type well past the queue size so that characters get dropped
  task automatic test_queue_overflow();
    logic [7:0] key;
    send_request(ACT_SCAN, {1'b1, SC_LCTRL});
    repeat (QUEUE_DEPTH + 12) begin
      key = 8'($urandom_range(2, 53));
      if (key[6:0] == SC_LCTRL || key[6:0] == SC_LSHIFT) key = 8'h1E;
      send_request(ACT_SCAN, key);
    end
  endtask

  // mix of keystrokes, modifier sequences, reads, flag tests and noise
  task automatic run_random_traffic(input int n_requests, input int read_pct,
                                    input int max_gap);
    int unsigned stop_at;
    int          pick;
    logic [7:0]  key;
    logic [7:0]  modifier;
    logic        with_shift;
    stop_at = requests_sent + unsigned'(n_requests);
    sender_max_gap = max_gap;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < read_pct) begin
        send_request(ACT_READ, 8'($urandom));
      end else if (pick < read_pct + 3) begin
        send_request(ACT_EOF, 8'($urandom));
      end else if (pick < read_pct + 5) begin
        send_request(ACT_NONE, 8'($urandom));
      end else if (pick < read_pct + 12) begin
        send_request(ACT_SCAN, 8'($urandom));
      end else if (pick < read_pct + 17) begin
        // ctrl chord, release sometimes lost
        send_request(ACT_SCAN, {1'b0, SC_LCTRL});
        case ($urandom_range(0, 9))
          0, 1, 2, 3: key = {1'b0, SC_KEY_C};
          4, 5, 6:    key = {1'b0, SC_KEY_D};
          default:    key = 8'($urandom_range(0, 63));
        endcase
        tap_key(key);
        if ($urandom_range(0, 7) != 0) send_request(ACT_SCAN, {1'b1, SC_LCTRL});
      end else if (pick < read_pct + 21) begin
        tap_key({1'b0, SC_CAPS});
      end else begin
        // ordinary keystroke, sometimes under either shift key
        with_shift = ($urandom_range(0, 2) == 0);
        modifier = $urandom_range(0, 1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT};
        key = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(64, 127)) :
                                             8'($urandom_range(0, 63));
        if (with_shift) send_request(ACT_SCAN, modifier);
        send_request(ACT_SCAN, key);
        if ($urandom_range(0, 9) != 0) send_request(ACT_SCAN, key | REL_BIT);
        if (with_shift) send_request(ACT_SCAN, modifier | REL_BIT);
      end
    end
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    kbd_result_t got;
    kbd_result_t want;
    logic        rx_next;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got = {rsp_ch.read_data, rsp_ch.eof_seen, rsp_ch.raise_interrupt,
               rsp_ch.wake_readers, rsp_ch.char_queued};
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result with nothing expected: data %h", got.read_data));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.read_data !== want.read_data || got.eof_seen !== want.eof_seen ||
              got.raise_interrupt !== want.raise_interrupt ||
              got.wake_readers !== want.wake_readers ||
              got.char_queued !== want.char_queued) begin
            report_failure($sformatf(
              "result %0d: expected data %h eof %b irq %b wake %b queued %b, got %h %b %b %b %b",
              results_checked, want.read_data, want.eof_seen, want.raise_interrupt,
              want.wake_readers, want.char_queued, got.read_data, got.eof_seen,
              got.raise_interrupt, got.wake_readers, got.char_queued));
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = rx_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        RX_STEADY: rx_next = 1'b1;
        RX_RANDOM: rx_next = ($urandom_range(0, 3) != 0);
        RX_SPARSE: rx_next = (rx_cycle % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rx_next = 1'b0;
          end else begin
            rx_next = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(5, 20);
          end
        end
      endcase
      rsp_ch.ready <= rx_next;
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no traffic for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_SCAN;
    req_ch.scan_code = 8'h00;
    shift_active = 1'b0;
    caps_on = 1'b0;
    ctrl_active = 1'b0;
    eof_flag = 1'b0;
    requests_sent = 0;
    chars_stored = 0;
    chars_dropped = 0;
    interrupts_seen = 0;
    eof_hits = 0;
    empty_reads = 0;
    burst_left = 0;
    sender_max_gap = 6;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_letters_and_shift();
    test_caps_lock();
    test_ctrl_keys();
    test_odd_codes();
    test_queue_overflow();
    run_random_traffic(350, 70, 8);
    run_random_traffic(200, 25, 0);
    run_random_traffic(200, 25, 8);

    // drain outstanding results
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests and checked %0d results, with stalls on both sides.",
             requests_sent, results_checked);
    $display("Chars stored %0d, dropped %0d, interrupts %0d, eof hits %0d, empty reads %0d.",
             chars_stored, chars_dropped, interrupts_seen, eof_hits, empty_reads);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures", failures);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
